### design/kcg_pkg.sv
// Package for the k-combination generator: field widths, codes, control word
// and flag types, and the microcode program of the sequencer.
// Depends on nothing.
package kcg_pkg;

  localparam int MODE_BITS      = 2;
  localparam int INDEX_BITS     = 4;
  localparam int STATUS_BITS    = 2;
  localparam int SLOT_BITS      = 3;
  localparam int LIST_LEN_BITS  = 5;
  localparam int PICK_BITS      = 4;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 5;
  localparam int STEP_BITS      = 4;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_LIST_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PICK_COUNT  = 2'd1;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_REQUEST = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_ELEM      = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_EXHAUSTED = 2'd2,
    STAT_ACK       = 2'd3
  } status_t;

  typedef enum logic [STEP_BITS-1:0] {
    ST_WAIT    = 4'd0,
    ST_DEC1    = 4'd1,
    ST_DEC2    = 4'd2,
    ST_DEC3    = 4'd3,
    ST_SCAN    = 4'd4,
    ST_EXH     = 4'd5,
    ST_REFILL  = 4'd6,
    ST_EMIT    = 4'd7,
    ST_FIRST   = 4'd8,
    ST_LOAD    = 4'd9,
    ST_RESTART = 4'd10,
    ST_EMPTY   = 4'd11
  } step_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_TAKE,
    ACT_SCAN_INIT,
    ACT_SCAN,
    ACT_REFILL,
    ACT_FIRST,
    ACT_EMIT,
    ACT_EXHAUST,
    ACT_LOAD,
    ACT_RESTART,
    ACT_EMPTY
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_MODE_LOAD,
    C_MODE_RESTART,
    C_MODE_NONE,
    C_BAD_REQ,
    C_K_ZERO,
    C_NOT_STARTED,
    C_CAN_RISE,
    C_PTR_NZ,
    C_LAST_SLOT
  } cond_t;

  typedef struct packed {
    act_t  act;
    logic  put;
    cond_t cond_a;
    step_t tgt_a;
    cond_t cond_b;
    step_t tgt_b;
  } ctl_t;

  typedef struct packed {
    logic hold;
    logic cmd_valid;
    logic mode_load;
    logic mode_restart;
    logic mode_none;
    logic bad_req;
    logic k_zero;
    logic not_started;
    logic can_rise;
    logic ptr_nz;
    logic last_slot;
  } flags_t;

  function automatic ctl_t kcg_rom(step_t step);
    ctl_t w;
    case (step)
      ST_WAIT:    w = '{ACT_TAKE,      1'b0, C_NO_ACCEPT,    ST_WAIT,   C_NEVER,        ST_WAIT};
      ST_DEC1:    w = '{ACT_NONE,      1'b0, C_MODE_LOAD,    ST_LOAD,   C_MODE_RESTART, ST_RESTART};
      ST_DEC2:    w = '{ACT_NONE,      1'b0, C_MODE_NONE,    ST_WAIT,   C_BAD_REQ,      ST_EXH};
      ST_DEC3:    w = '{ACT_SCAN_INIT, 1'b0, C_K_ZERO,       ST_EMPTY,  C_NOT_STARTED,  ST_FIRST};
      ST_SCAN:    w = '{ACT_SCAN,      1'b0, C_CAN_RISE,     ST_REFILL, C_PTR_NZ,       ST_SCAN};
      ST_EXH:     w = '{ACT_EXHAUST,   1'b1, C_ALWAYS,       ST_WAIT,   C_NEVER,        ST_WAIT};
      ST_REFILL:  w = '{ACT_REFILL,    1'b0, C_NEVER,        ST_WAIT,   C_NEVER,        ST_WAIT};
      ST_EMIT:    w = '{ACT_EMIT,      1'b1, C_LAST_SLOT,    ST_WAIT,   C_ALWAYS,       ST_EMIT};
      ST_FIRST:   w = '{ACT_FIRST,     1'b0, C_ALWAYS,       ST_EMIT,   C_NEVER,        ST_WAIT};
      ST_LOAD:    w = '{ACT_LOAD,      1'b1, C_ALWAYS,       ST_WAIT,   C_NEVER,        ST_WAIT};
      ST_RESTART: w = '{ACT_RESTART,   1'b1, C_ALWAYS,       ST_WAIT,   C_NEVER,        ST_WAIT};
      ST_EMPTY:   w = '{ACT_EMPTY,     1'b1, C_ALWAYS,       ST_WAIT,   C_NEVER,        ST_WAIT};
      default:    w = '{ACT_NONE,      1'b0, C_ALWAYS,       ST_WAIT,   C_NEVER,        ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

### design/kcg_if.sv
// Channel interfaces of the k-combination generator: command words in,
// result words out. Depends on kcg_pkg.
interface kcg_cmd_if import kcg_pkg::*; #(parameter int VALUE_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic [MODE_BITS-1:0]         mode;
  logic [INDEX_BITS-1:0]        load_index;
  logic signed [VALUE_BITS-1:0] load_value;

  modport source (output valid, mode, load_index, load_value, input ready);
  modport sink (input valid, mode, load_index, load_value, output ready);
endinterface

interface kcg_res_if import kcg_pkg::*; #(parameter int VALUE_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic [STATUS_BITS-1:0]       status;
  logic [SLOT_BITS-1:0]         slot;
  logic signed [VALUE_BITS-1:0] element;
  logic                         last;

  modport source (output valid, status, slot, element, last, input ready);
  modport sink (input valid, status, slot, element, last, output ready);
endinterface

### design/kcg_seq.sv
// Microcode sequencer: step counter, program table lookup and branch select.
// Depends on kcg_pkg.
module kcg_seq import kcg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output ctl_t   ctl
);

  step_t step;
  step_t step_next;

  function automatic logic test(cond_t c, flags_t f);
    logic r;
    case (c)
      C_NEVER:        r = 1'b0;
      C_ALWAYS:       r = 1'b1;
      C_NO_ACCEPT:    r = !f.cmd_valid;
      C_MODE_LOAD:    r = f.mode_load;
      C_MODE_RESTART: r = f.mode_restart;
      C_MODE_NONE:    r = f.mode_none;
      C_BAD_REQ:      r = f.bad_req;
      C_K_ZERO:       r = f.k_zero;
      C_NOT_STARTED:  r = f.not_started;
      C_CAN_RISE:     r = f.can_rise;
      C_PTR_NZ:       r = f.ptr_nz;
      C_LAST_SLOT:    r = f.last_slot;
      default:        r = 1'b0;
    endcase
    return r;
  endfunction

  assign ctl = kcg_rom(step);

  always_comb begin
    if (flags.hold) begin
      step_next = step;
    end else if (test(ctl.cond_a, flags)) begin
      step_next = ctl.tgt_a;
    end else if (test(ctl.cond_b, flags)) begin
      step_next = ctl.tgt_b;
    end else begin
      step_next = step_t'(step + STEP_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

  a_wait_take: assert property (@(posedge clk) disable iff (rst)
    (step == ST_WAIT && flags.cmd_valid) |=> step == ST_DEC1)
    else $error("accepted word did not start decode");

  a_last_emit_to_wait: assert property (@(posedge clk) disable iff (rst)
    (step == ST_EMIT && !flags.hold && flags.last_slot) |=> step == ST_WAIT)
    else $error("last element did not return to wait");

  a_scan_fail_to_exh: assert property (@(posedge clk) disable iff (rst)
    (step == ST_SCAN && !flags.can_rise && !flags.ptr_nz) |=> step == ST_EXH)
    else $error("failed scan did not report exhausted");

endmodule

### design/kcg_dpath.sv
// Datapath: configuration registers, enumeration flags, chosen positions,
// value table memory and the result output register. Depends on kcg_pkg, kcg_if.
module kcg_dpath import kcg_pkg::*; #(
  parameter int MAX_LIST   = 16,
  parameter int MAX_PICK   = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  kcg_cmd_if.sink                   cmd,
  kcg_res_if.source                 res,
  input  ctl_t                      ctl,
  output flags_t                    flags
);

  localparam int PW = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
  localparam int NW = $clog2(MAX_LIST + 1);
  localparam int KW = $clog2(MAX_PICK + 1);
  localparam int IW = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
  localparam int LW = ((NW > KW) ? NW : KW) + 1;

  logic [LIST_LEN_BITS-1:0] list_length;
  logic [PICK_BITS-1:0]     pick_count;
  logic                     started;
  logic                     finished;
  logic [NW-1:0]            n;
  logic [KW-1:0]            k;

  logic [MODE_BITS-1:0]     mode_q;
  logic [INDEX_BITS-1:0]    index_q;
  logic [VALUE_BITS-1:0]    value_q;

  logic [PW-1:0]            pos [MAX_PICK];
  logic [IW-1:0]            ptr;
  logic [IW-1:0]            oslot;

  logic [VALUE_BITS-1:0]    table_mem [MAX_LIST];
  logic [VALUE_BITS-1:0]    rd_data;
  logic [PW-1:0]            rd_addr;

  logic                     out_valid;
  status_t                  out_status;
  logic [SLOT_BITS-1:0]     out_slot;
  logic [VALUE_BITS-1:0]    out_element;
  logic                     out_last;

  logic hold;
  logic go;
  logic accept;
  logic can_rise;
  logic last_slot;

  always_comb begin
    if (int'(list_length) > MAX_LIST) begin
      n = NW'(MAX_LIST);
    end else begin
      n = NW'(list_length);
    end
    if (int'(pick_count) > MAX_PICK) begin
      k = KW'(MAX_PICK);
    end else begin
      k = KW'(pick_count);
    end
  end

  assign can_rise  = LW'(pos[ptr]) < (LW'(n) + LW'(ptr) - LW'(k));
  assign last_slot = (KW'(oslot) + KW'(1)) == k;
  assign hold      = ctl.put && out_valid && !res.ready;
  assign go        = !hold;
  assign cmd.ready = (ctl.act == ACT_TAKE);
  assign accept    = cmd.valid && cmd.ready;

  assign flags.hold         = hold;
  assign flags.cmd_valid    = cmd.valid;
  assign flags.mode_load    = (mode_q == MODE_LOAD);
  assign flags.mode_restart = (mode_q == MODE_RESTART);
  assign flags.mode_none    = (mode_q == MODE_NONE);
  assign flags.bad_req      = finished || (LW'(k) > LW'(n)) || (k == '0 && started);
  assign flags.k_zero       = (k == '0);
  assign flags.not_started  = !started;
  assign flags.can_rise     = can_rise;
  assign flags.ptr_nz       = (ptr != '0);
  assign flags.last_slot    = last_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      list_length <= '0;
      pick_count  <= '0;
      started     <= 1'b0;
      finished    <= 1'b0;
    end else begin
      if (go) begin
        case (ctl.act)
          ACT_RESTART: begin
            started  <= 1'b0;
            finished <= 1'b0;
          end
          ACT_EXHAUST: finished <= 1'b1;
          ACT_EMPTY: begin
            started  <= 1'b1;
            finished <= 1'b1;
          end
          ACT_FIRST: started <= 1'b1;
          default: ;
        endcase
      end
      if (cfg_we) begin
        if (cfg_index == CFG_LIST_LENGTH) begin
          list_length <= cfg_data[LIST_LEN_BITS-1:0];
          started     <= 1'b0;
          finished    <= 1'b0;
        end else if (cfg_index == CFG_PICK_COUNT) begin
          pick_count <= cfg_data[PICK_BITS-1:0];
          started    <= 1'b0;
          finished   <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= cmd.mode;
      index_q <= cmd.load_index;
      value_q <= cmd.load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      case (ctl.act)
        ACT_SCAN_INIT: ptr <= IW'(k - KW'(1));
        ACT_SCAN: begin
          if (can_rise) begin
            pos[ptr] <= pos[ptr] + PW'(1);
          end else begin
            ptr <= ptr - IW'(1);
          end
        end
        ACT_REFILL: begin
          for (int j = 0; j < MAX_PICK; j++) begin
            if (j > int'(ptr)) begin
              pos[j] <= PW'(int'(pos[ptr]) + j - int'(ptr));
            end
          end
          ptr   <= IW'(1);
          oslot <= '0;
        end
        ACT_FIRST: begin
          for (int j = 0; j < MAX_PICK; j++) begin
            pos[j] <= PW'(j);
          end
          ptr   <= IW'(1);
          oslot <= '0;
        end
        ACT_EMIT: begin
          ptr   <= ptr + IW'(1);
          oslot <= oslot + IW'(1);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ctl.act)
      ACT_FIRST:  rd_addr = '0;
      ACT_REFILL: rd_addr = pos[0];
      default:    rd_addr = pos[ptr];
    endcase
  end

  always_ff @(posedge clk) begin
    if (go && ctl.act == ACT_LOAD && int'(index_q) < MAX_LIST) begin
      table_mem[PW'(index_q)] <= value_q;
    end
    if (go && (ctl.act == ACT_FIRST || ctl.act == ACT_REFILL || ctl.act == ACT_EMIT)) begin
      rd_data <= table_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && ctl.put) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && ctl.put) begin
      case (ctl.act)
        ACT_EMIT: begin
          out_status  <= STAT_ELEM;
          out_slot    <= SLOT_BITS'(oslot);
          out_element <= rd_data;
          out_last    <= last_slot;
        end
        ACT_EXHAUST: begin
          out_status  <= STAT_EXHAUSTED;
          out_slot    <= '0;
          out_element <= '0;
          out_last    <= 1'b1;
        end
        ACT_EMPTY: begin
          out_status  <= STAT_EMPTY;
          out_slot    <= '0;
          out_element <= '0;
          out_last    <= 1'b1;
        end
        default: begin
          out_status  <= STAT_ACK;
          out_slot    <= '0;
          out_element <= '0;
          out_last    <= 1'b1;
        end
      endcase
    end
  end

  assign res.valid   = out_valid;
  assign res.status  = out_status;
  assign res.slot    = out_slot;
  assign res.element = out_element;
  assign res.last    = out_last;

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (ctl.act == ACT_EMIT && go) |-> (KW'(oslot) < k))
    else $error("element slot beyond pick count");

  a_put_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (go && ctl.put) |=> out_valid)
    else $error("result word lost");

  a_drop_on_ready: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> ($past(res.ready) || $past(rst)))
    else $error("result word dropped without ready");

endmodule

### design/k_combination_generator.sv
// Top level of the k-combination generator: microcode sequencer plus datapath.
// Depends on kcg_pkg, kcg_if, kcg_seq, kcg_dpath.
//
//   channel  dir  word                                   taken when
//   cmd      in   mode, load_index, load_value           cmd.valid && cmd.ready
//   res      out  status, slot, element, last            res.valid && res.ready
//   cfg      in   cfg_index, cfg_data                    cfg_we
//
// Request: the position scan walks one chosen position per cycle, then one table
// read per element. Exhausted is reported when a request is refused at decode
// or when the scan runs out; mode three gives no word.
// Reset is synchronous; list and pick count go to 0, enumeration restarts.
// A full output register that is not taken holds the sequencer in a step that puts a word.
module k_combination_generator import kcg_pkg::*; #(
  parameter int MAX_LIST   = 16,
  parameter int MAX_PICK   = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  kcg_cmd_if.sink                   cmd,
  kcg_res_if.source                 res
);

  ctl_t   ctl;
  flags_t flags;

  kcg_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  kcg_dpath #(
    .MAX_LIST   (MAX_LIST),
    .MAX_PICK   (MAX_PICK),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .res       (res),
    .ctl       (ctl),
    .flags     (flags)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Testbench for k_combination_generator: a scoreboard class tracks the
// enumeration and checks every result word against its own prediction.
// Depends on kcg_pkg, kcg_if and the design under design/.
module tb;
  import kcg_pkg::*;

  localparam int MAX_LIST      = 16;
  localparam int MAX_PICK      = 8;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 33;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd2;

  typedef struct packed {
    status_t            status;
    logic [2:0]         slot;
    logic signed [31:0] element;
    logic               last;
  } result_word_t;

  class combo_tracker;
    logic signed [31:0] value_mem [MAX_LIST];
    logic [4:0]         positions [MAX_PICK];
    logic [4:0]         list_len = '0;
    logic [3:0]         pick = '0;
    bit                 started = 0;
    bit                 finished = 0;
    int                 errors = 0;
    result_word_t       expected_words [$];

    function void push_word(status_t status, int slot, logic signed [31:0] element, bit last);
      result_word_t w;
      w.status  = status;
      w.slot    = slot[2:0];
      w.element = element;
      w.last    = last;
      expected_words = {expected_words, w};
    endfunction

    function void exhaust();
      finished = 1;
      push_word(STAT_EXHAUSTED, 0, '0, 1);
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] data);
      if (index == CFG_LIST_LENGTH) begin
        list_len = data;
      end else if (index == CFG_PICK_COUNT) begin
        pick = data[3:0];
      end else begin
        return;
      end
      started  = 0;
      finished = 0;
    endfunction

    function void note_command(mode_t mode, logic [3:0] idx, logic signed [31:0] value);
      int n, k, i, j;
      bit moved;
      case (mode)
        MODE_LOAD: begin
          value_mem[idx] = value;
          push_word(STAT_ACK, 0, '0, 1);
        end
        MODE_RESTART: begin
          started  = 0;
          finished = 0;
          push_word(STAT_ACK, 0, '0, 1);
        end
        MODE_REQUEST: begin
          n = (list_len > MAX_LIST) ? MAX_LIST : int'(list_len);
          k = (pick > MAX_PICK) ? MAX_PICK : int'(pick);
          if (finished || k > n) begin
            exhaust();
          end else if (k == 0) begin
            if (started) begin
              exhaust();
            end else begin
              started  = 1;
              finished = 1;
              push_word(STAT_EMPTY, 0, '0, 1);
            end
          end else begin
            moved = 0;
            if (!started) begin
              for (i = 0; i < k; i++) positions[i] = 5'(i);
              started = 1;
              moved   = 1;
            end else begin
              for (i = k - 1; i >= 0 && !moved; i--) begin
                if (int'(positions[i]) < n - k + i) begin
                  positions[i]++;
                  for (j = i + 1; j < k; j++) positions[j] = positions[j-1] + 5'd1;
                  moved = 1;
                end
              end
            end
            if (!moved) begin
              exhaust();
            end else begin
              for (i = 0; i < k; i++)
                push_word(STAT_ELEM, i, value_mem[positions[i][3:0]], i == k - 1);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_word(status_t status, logic [2:0] slot, logic signed [31:0] element,
                             logic last);
      result_word_t want;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: status %0d slot %0d element %0d last %0d",
                   status, slot, element, last);
        return;
      end
      want = expected_words.pop_front();
      if (status !== want.status || slot !== want.slot || element !== want.element ||
          last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected status %0d slot %0d element %0d last %0d, ",
                    "got %0d %0d %0d %0d"},
                   want.status, want.slot, want.element, want.last,
                   status, slot, element, last);
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  kcg_cmd_if #(.VALUE_BITS(32)) cmd_ch ();
  kcg_res_if #(.VALUE_BITS(32)) res_ch ();

  k_combination_generator #(
    .MAX_LIST  (MAX_LIST),
    .MAX_PICK  (MAX_PICK),
    .VALUE_BITS(32)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd_ch),
    .res      (res_ch)
  );

  combo_tracker sb;
  int           tx_idle_pct = 0;
  int           rx_stall_pct = 0;
  bit           hold_off = 0;
  int           cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_word(status_t'(res_ch.status), res_ch.slot, res_ch.element, res_ch.last);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: errors");
    $finish;
  end

  task automatic send_cmd(input mode_t mode, input logic [3:0] idx,
                          input logic signed [31:0] value);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
    end
    @(negedge clk);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.mode       <= mode;
    cmd_ch.load_index <= idx;
    cmd_ch.load_value <= value;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sb.note_command(mode, idx, value);
  endtask

  task automatic send_random();
    int    roll;
    mode_t mode;
    roll = $urandom_range(0, 99);
    if (roll < 70)      mode = MODE_REQUEST;
    else if (roll < 85) mode = MODE_LOAD;
    else if (roll < 95) mode = MODE_RESTART;
    else                mode = MODE_NONE;
    send_cmd(mode, 4'($urandom_range(0, 15)), $urandom);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(index, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic signed [31:0] extreme_vals [6];
    int                 n, k;
    extreme_vals = '{32'sh80000000, 32'sh7fffffff, 32'sh0, -32'sd1,
                     32'shaaaaaaaa, 32'sh55555555};
    sb = new;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.mode       = MODE_NONE;
    cmd_ch.load_index = '0;
    cmd_ch.load_value = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < MAX_LIST; i++)
      send_cmd(MODE_LOAD, 4'(i), (i < 6) ? extreme_vals[i] : 32'($urandom));
    send_cmd(MODE_REQUEST, 4'hf, 32'sh0);
    send_cmd(MODE_REQUEST, 4'h0, -32'sd1);
    send_cmd(MODE_NONE, 4'ha, 32'sh5a5a5a5a);
    send_cmd(MODE_RESTART, 4'h5, 32'sh12345678);
    send_cmd(MODE_REQUEST, 4'h3, 32'sh0);
    wait_quiet();
    write_reg(CFG_LIST_LENGTH, 5'd3);
    write_reg(CFG_PICK_COUNT, 5'd2);
    repeat (4) send_cmd(MODE_REQUEST, 4'($urandom_range(0, 15)), $urandom);

    for (int phase = 0; phase < 9; phase++) begin
      wait_quiet();
      case (phase)
        0: begin n = 16; k = 8;  end
        1: begin n = 31; k = 1;  end
        2: begin n = 5;  k = 5;  end
        3: begin n = 6;  k = 18; end
        4: begin n = 3;  k = 7;  end
        5: begin n = 7;  k = 0;  end
        6: begin n = 4;  k = 3;  end
        7: begin n = $urandom_range(1, 8); k = $urandom_range(0, n); end
        default: begin n = 16; k = 15; end
      endcase
      write_reg(CFG_LIST_LENGTH, 5'(n));
      write_reg(CFG_PICK_COUNT, 5'(k));
      if (phase == 3) write_reg(CFG_UNUSED, 5'd31);
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
      endcase
      if (phase == 0) hold_off = 1;
      repeat (PHASE_ITEMS) send_random();
    end

    wait_quiet();
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
